// ===== hdl/crr_pkg.sv =====
`timescale 1ns / 1ps

package crr_pkg;

   localparam int RADIUS_BITS = 10;
   localparam int COORD_BITS  = 12;
   localparam int OUT_BITS    = COORD_BITS + 1;

   localparam int ROOT_STAGES = (RADIUS_BITS + 1) / 2;
   localparam int ROOT_BITS   = 2 * ROOT_STAGES;
   localparam int NUM_BITS    = 2 * ROOT_BITS;
   localparam int REM_BITS    = ROOT_BITS + 2;
   localparam int DX_SHIFT    = ROOT_BITS - RADIUS_BITS;
   localparam int PAD_SHIFT   = 2 * DX_SHIFT;
   localparam int PROD_BITS   = 2 * RADIUS_BITS + 1;
   localparam int CALC_BITS   = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 3;

   localparam logic [1:0] LAST_LINE  = 2'd1;
   localparam logic [1:0] LAST_POINT = 2'd3;

   typedef struct packed {
      logic                  pt;
      logic [COORD_BITS-1:0] cx;
      logic [OUT_BITS-1:0]   y_low;
      logic [OUT_BITS-1:0]   y_high;
      logic [NUM_BITS-1:0]   n;
      logic [REM_BITS-1:0]   rem;
      logic [ROOT_BITS-1:0]  root;
   } crr_item_type;

   typedef struct packed {
      logic                pt;
      logic [OUT_BITS-1:0] x_plus;
      logic [OUT_BITS-1:0] x_minus;
      logic [OUT_BITS-1:0] y_low;
      logic [OUT_BITS-1:0] y_high;
   } crr_out_type;

   // one digit of the restoring square root, top two bits of n first
   function automatic crr_item_type root_step(crr_item_type a);
      crr_item_type         b;
      logic [REM_BITS-1:0]  cur;
      logic [REM_BITS-1:0]  trial;
      b     = a;
      cur   = {a.rem[REM_BITS-3:0], a.n[NUM_BITS-1 -: 2]};
      trial = {a.root, 2'b01};
      if (cur >= trial) begin
         b.rem  = cur - trial;
         b.root = {a.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         b.rem  = cur;
         b.root = {a.root[ROOT_BITS-2:0], 1'b0};
      end
      b.n = a.n << 2;
      return b;
   endfunction

endpackage

// ===== hdl/crr_root_stage.sv =====
`timescale 1ns / 1ps

module crr_root_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  crr_pkg::crr_item_type in_item,
   output logic                 in_ready,
   output logic                 out_valid,
   output crr_pkg::crr_item_type out_item,
   input  logic                 out_ready
);

   logic                  valid_ff;
   crr_pkg::crr_item_type item_ff;
   crr_pkg::crr_item_type item_in;

   assign item_in   = crr_pkg::root_step(crr_pkg::root_step(in_item));
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== hdl/circle_row_rasterizer_core.sv =====
`timescale 1ns / 1ps
// Circle row rasterizer.
// Input channel req_*: one circle row per transfer (mode, centre, radius, row).
// Result channel rsp_*: the spans or points of that row, one per transfer,
// with rsp_last high on the final one. Fill rows give two lines, outline
// row 0 gives two cap lines, outline rows 1..r give four points. Rows past
// the radius, and fill row 0, give nothing and are dropped at the first stage.
// Pipeline: input stage (multiply for 2*r*dy - dy*dy), five square root
// stages of two digits each, an add stage for the x ends, and the output
// register. A new row is taken every cycle while the pipeline has room;
// sustained rate is set by the output register, which sends one result per
// cycle while rsp_ready is high.
// When rsp_ready is low the output register holds and each stage keeps its
// item until the next one frees up, so req_ready falls only once the whole
// pipeline is full. Nothing is lost or repeated.
// Synchronous reset empties all stages; there is no other state.
module circle_row_rasterizer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic signed [crr_pkg::COORD_BITS-1:0] req_center_x,
   input  logic signed [crr_pkg::COORD_BITS-1:0] req_center_y,
   input  logic [crr_pkg::RADIUS_BITS-1:0]       req_radius,
   input  logic [crr_pkg::RADIUS_BITS-1:0]       req_row,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_kind,
   output logic signed [crr_pkg::OUT_BITS-1:0]   rsp_x_start,
   output logic signed [crr_pkg::OUT_BITS-1:0]   rsp_y_start,
   output logic signed [crr_pkg::OUT_BITS-1:0]   rsp_x_end,
   output logic signed [crr_pkg::OUT_BITS-1:0]   rsp_y_end,
   output logic                                  rsp_last
);

   localparam int NS = crr_pkg::ROOT_STAGES;
   localparam int RB = crr_pkg::RADIUS_BITS;
   localparam int CB = crr_pkg::COORD_BITS;
   localparam int OB = crr_pkg::OUT_BITS;
   localparam int CW = crr_pkg::CALC_BITS;

   // input stage
   logic                      a_valid_ff;
   logic                      a_valid_in;
   crr_pkg::crr_item_type     a_item_ff;
   crr_pkg::crr_item_type     a_item_in;
   logic                      keep;
   logic [RB:0]               two_r;
   logic [RB:0]               two_r_minus;
   logic [crr_pkg::PROD_BITS-1:0] prod;
   logic [2*RB-1:0]           num;
   logic [CW-1:0]             cy_w;
   logic [CW-1:0]             r_w;
   logic [CW-1:0]             dy_w;
   logic [CW-1:0]             y_low_w;
   logic [CW-1:0]             y_high_w;

   assign keep        = (req_row <= req_radius) && (req_op || (req_row != '0));
   assign two_r       = {req_radius, 1'b0};
   assign two_r_minus = two_r - {1'b0, req_row};
   assign prod        = {{(RB+1){1'b0}}, req_row} * {{RB{1'b0}}, two_r_minus};
   assign num         = (req_row == '0) ? (2*RB)'(two_r) : prod[2*RB-1:0];
   assign cy_w        = {{(CW-CB){req_center_y[CB-1]}}, req_center_y};
   assign r_w         = {{(CW-RB){1'b0}}, req_radius};
   assign dy_w        = {{(CW-RB){1'b0}}, req_row};
   assign y_low_w     = cy_w + r_w - dy_w;
   assign y_high_w    = cy_w - r_w + dy_w;

   always_comb begin
      a_item_in        = '0;
      a_item_in.pt     = req_op && (req_row != '0);
      a_item_in.cx     = req_center_x;
      a_item_in.y_low  = y_low_w[OB-1:0];
      a_item_in.y_high = y_high_w[OB-1:0];
      a_item_in.n      = crr_pkg::NUM_BITS'(num) << crr_pkg::PAD_SHIFT;
   end

   logic                  root_valid [0:NS];
   logic                  root_ready [0:NS];
   crr_pkg::crr_item_type root_item  [0:NS];

   assign req_ready  = !a_valid_ff || root_ready[0];
   assign a_valid_in = req_valid && keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && a_valid_in) begin
         a_item_ff <= a_item_in;
      end
   end

   assign root_valid[0] = a_valid_ff;
   assign root_item[0]  = a_item_ff;

   // square root stages
   genvar s;
   generate
      for (s = 0; s < NS; s++) begin : g_root
         crr_root_stage u_stage (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (root_valid[s]),
            .in_item   (root_item[s]),
            .in_ready  (root_ready[s]),
            .out_valid (root_valid[s+1]),
            .out_item  (root_item[s+1]),
            .out_ready (root_ready[s+1])
         );
      end
   endgenerate

   // add stage: x ends
   logic                 b_valid_ff;
   logic                 b_ready;
   crr_pkg::crr_out_type b_item_ff;
   crr_pkg::crr_out_type b_item_in;
   logic [RB-1:0]        dx;
   logic [CW-1:0]        cx_w;
   logic [CW-1:0]        dx_w;
   logic [CW-1:0]        xp_w;
   logic [CW-1:0]        xm_w;
   logic                 o_free;

   assign dx   = RB'(root_item[NS].root >> crr_pkg::DX_SHIFT);
   assign cx_w = {{(CW-CB){root_item[NS].cx[CB-1]}}, root_item[NS].cx};
   assign dx_w = {{(CW-RB){1'b0}}, dx};
   assign xp_w = cx_w + dx_w;
   assign xm_w = cx_w - dx_w;

   always_comb begin
      b_item_in.pt      = root_item[NS].pt;
      b_item_in.x_plus  = xp_w[OB-1:0];
      b_item_in.x_minus = xm_w[OB-1:0];
      b_item_in.y_low   = root_item[NS].y_low;
      b_item_in.y_high  = root_item[NS].y_high;
   end

   assign b_ready        = !b_valid_ff || o_free;
   assign root_ready[NS] = b_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= root_valid[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && root_valid[NS]) begin
         b_item_ff <= b_item_in;
      end
   end

   // output register, one result per transfer
   logic                 o_valid_ff;
   logic [1:0]           cnt_ff;
   crr_pkg::crr_out_type o_item_ff;

   assign rsp_valid   = o_valid_ff;
   assign rsp_last    = o_item_ff.pt ? (cnt_ff == crr_pkg::LAST_POINT)
                                     : (cnt_ff == crr_pkg::LAST_LINE);
   assign rsp_kind    = o_item_ff.pt;
   assign rsp_y_start = cnt_ff[0] ? o_item_ff.y_high : o_item_ff.y_low;
   assign rsp_y_end   = rsp_y_start;
   assign rsp_x_start = (o_item_ff.pt && !cnt_ff[1]) ? o_item_ff.x_plus : o_item_ff.x_minus;
   assign rsp_x_end   = (o_item_ff.pt && cnt_ff[1]) ? o_item_ff.x_minus : o_item_ff.x_plus;
   assign o_free      = !o_valid_ff || (rsp_ready && rsp_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         cnt_ff     <= '0;
      end else if (o_free) begin
         o_valid_ff <= b_valid_ff;
         cnt_ff     <= '0;
      end else if (rsp_ready) begin
         cnt_ff     <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (o_free && b_valid_ff) begin
         o_item_ff <= b_item_ff;
      end
   end

   a_line_count: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !o_item_ff.pt) |-> (cnt_ff <= crr_pkg::LAST_LINE))
      else $error("line row counter past its last result");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (cnt_ff == 2'd0))
      else $error("counter not cleared after last transfer");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(cnt_ff) && $stable(o_item_ff)))
      else $error("output register changed while stalled");

   a_point_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> (rsp_x_end == rsp_x_start))
      else $error("point result with differing x ends");

endmodule
